/* sv/assert_macros.svh */
// Concurrent assertion helpers, sampled on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/tcw_pkg.sv */
`default_nettype none
package tcw_pkg;
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = 11;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int CELL_W     = 16;

   localparam logic [CELL_W-1:0] BLANK_CELL     = 16'h0700;
   localparam logic [CELL_W-1:0] ATTR_MASK      = 16'hFF00;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_NULL      = 8'h00;
   localparam logic              CMD_PUT        = 1'b0;
   localparam logic              CMD_READ       = 1'b1;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
   } mem_req_type;
endpackage
`default_nettype wire

/* sv/tcw_if.sv */
`default_nettype none
interface tcw_req_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic              command;
   logic [CHAR_W-1:0] char_code;
   logic [ADDR_W-1:0] cell_index;
   modport source (output valid, command, char_code, cell_index, input ready);
   modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_value;
   logic [ROW_W-1:0]  cursor_row;
   logic [COL_W-1:0]  cursor_col;
   modport source (output valid, cell_value, cursor_row, cursor_col, input ready);
   modport sink   (input valid, cell_value, cursor_row, cursor_col, output ready);
endinterface
`default_nettype wire

/* sv/tcw_cell_store.sv */
`default_nettype none
module tcw_cell_store (
   input  wire                          clock,
   input  tcw_pkg::mem_req_type         mem_req,
   output logic [tcw_pkg::CELL_W-1:0]   rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] cells [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         cells[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= cells[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* sv/tcw_ctrl.sv */
`default_nettype none
module tcw_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   tcw_req_if.sink                      req_ch,
   tcw_rsp_if.source                    rsp_ch,
   output tcw_pkg::mem_req_type         mem_req,
   input  wire [tcw_pkg::CELL_W-1:0]    rd_data
);
   import tcw_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_RDWAIT = 4'd3;
   localparam logic [3:0] S_BSWB   = 4'd4;
   localparam logic [3:0] S_PRWB   = 4'd5;
   localparam logic [3:0] S_SCROLL = 4'd6;
   localparam logic [3:0] S_FLUSH  = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - COLUMNS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

   logic [3:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              cmd_ff, cmd_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              swp_pend_ff, swp_pend_in;
   logic [ADDR_W-1:0] swp_addr_ff, swp_addr_in;
   logic [CELL_W-1:0] res_value_ff, res_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ADDR_W-1:0] cur_addr;
   logic              slot_free;

   assign cur_addr  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cell_value = rsp_value_ff;
   assign rsp_ch.cursor_row = rsp_row_ff;
   assign rsp_ch.cursor_col = rsp_col_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      wb_addr_in   = wb_addr_ff;
      cnt_in       = cnt_ff;
      swp_pend_in  = 1'b0;
      swp_addr_in  = swp_addr_ff;
      res_value_in = res_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      mem_req      = '0;

      // scroll write-back, in the cycle after its read
      if (swp_pend_ff) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = swp_addr_ff;
         mem_req.wr_data = (swp_addr_ff < COPY_END) ? rd_data : (rd_data & ATTR_MASK);
      end

      case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff;
            mem_req.wr_data = BLANK_CELL;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               ch_in    = req_ch.char_code;
               idx_in   = req_ch.cell_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_value_in = '0;
            state_in     = S_EMIT;
            if (cmd_ff == CMD_READ) begin
               if (idx_ff <= LAST_CELL) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff;
                  state_in        = S_RDWAIT;
               end
            end else if (ch_ff == CODE_BACKSPACE) begin
               if (row_ff != '0 || col_ff != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = cur_addr - 1'b1;
                  wb_addr_in      = cur_addr - 1'b1;
                  state_in        = S_BSWB;
                  if (col_ff != '0) begin
                     col_in = col_ff - 1'b1;
                  end else begin
                     col_in = LAST_COL;
                     row_in = row_ff - 1'b1;
                  end
               end
            end else if (ch_ff == CODE_NEWLINE) begin
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  cnt_in   = '0;
                  state_in = S_SCROLL;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else if (ch_ff != CODE_NULL) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cur_addr;
               wb_addr_in      = cur_addr;
               state_in        = S_PRWB;
            end
         end
         S_RDWAIT: begin
            res_value_in = rd_data;
            state_in     = S_EMIT;
         end
         S_BSWB: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wb_addr_ff;
            mem_req.wr_data = rd_data & ATTR_MASK;
            state_in        = S_EMIT;
         end
         S_PRWB: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wb_addr_ff;
            mem_req.wr_data = (rd_data & ATTR_MASK) | CELL_W'(ch_ff);
            state_in        = S_EMIT;
            if (col_ff == LAST_COL) begin
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  cnt_in   = '0;
                  state_in = S_SCROLL;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_SCROLL: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = (cnt_ff < COPY_END) ? cnt_ff + ADDR_W'(COLUMNS) : cnt_ff;
            swp_pend_in     = 1'b1;
            swp_addr_in     = cnt_ff;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         swp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         swp_pend_ff  <= swp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      ch_ff        <= ch_in;
      idx_ff       <= idx_in;
      wb_addr_ff   <= wb_addr_in;
      swp_addr_ff  <= swp_addr_in;
      res_value_ff <= res_value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end
endmodule
`default_nettype wire

/* sv/text_console_writer.sv */
// channel  | dir | handshake    | payload
// req_ch   | in  | valid/ready  | command, char_code, cell_index
// rsp_ch   | out | valid/ready  | cell_value, cursor_row, cursor_col
//
// One request at a time: an accepted request passes S_EXEC, then S_RDWAIT, S_BSWB
// or S_PRWB if it touches the cell memory (not for a null byte, a plain newline or
// an out-of-range read), then S_EMIT. A newline or wrap on the bottom row adds a
// scroll pass over all ROWS*COLUMNS cells, one read and one write of the simple
// dual-port cell memory per cycle. After reset a clearing pass fills the memory
// with blank cells; req_ch.ready stays low until it ends.
// A stalled result sits in the output register while the next request is taken.
`default_nettype none
module text_console_writer (
   input  wire        clock,
   input  wire        reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch
);
   import tcw_pkg::*;

   mem_req_type       mem_req;
   logic [CELL_W-1:0] rd_data;

   tcw_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   tcw_cell_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );
endmodule
`default_nettype wire

/* sv/tcw_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module tcw_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [tcw_pkg::CELL_W-1:0]    cell_value,
   input wire [tcw_pkg::ROW_W-1:0]     cursor_row,
   input wire [tcw_pkg::COL_W-1:0]     cursor_col
);
   import tcw_pkg::*;

   `ASSERT_CLK_ALWAYS(a_clear_after_reset, reset |=> !req_ready, "ready during clear pass")
   `ASSERT_CLK(a_one_at_a_time, (req_valid && req_ready) |=> !req_ready, "back-to-back accept")
   `ASSERT_CLK(a_cursor_range, rsp_valid |-> (cursor_row <= ROW_W'(ROWS - 1) && cursor_col <= COL_W'(COLUMNS - 1)), "cursor out of range")
   `ASSERT_CLK(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cell_value)), "stalled response changed")
endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .cell_value (rsp_ch.cell_value),
   .cursor_row (rsp_ch.cursor_row),
   .cursor_col (rsp_ch.cursor_col)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import tcw_pkg::*;

   typedef struct packed {
      logic [CELL_W-1:0] cell_val;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } readout_type;

   logic clock;
   logic reset;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // console mirror
   logic [CELL_W-1:0] screen_mirror [CELL_COUNT];
   int unsigned       cur_row;
   int unsigned       cur_col;

   readout_type awaited_readouts [$];
   int       mismatches;
   int       sender_idle_pct;
   int       sink_stall_pct;
   int       n_chars, n_newlines, n_backspaces, n_nulls, n_reads, n_scrolls;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void scroll_mirror();
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
         screen_mirror[i] = screen_mirror[i + COLUMNS];
      end
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
         screen_mirror[i] = screen_mirror[i] & ATTR_MASK;
      end
      n_scrolls++;
   endfunction

   function automatic void advance_row();
      cur_col = 0;
      if (cur_row + 1 < ROWS) begin
         cur_row++;
      end else begin
         scroll_mirror();
      end
   endfunction

   function automatic readout_type console_apply(logic cmd, logic [CHAR_W-1:0] ch,
                                                 logic [ADDR_W-1:0] idx);
      readout_type r;
      int unsigned pos;
      r = '0;
      if (cmd == CMD_READ) begin
         n_reads++;
         if (idx < CELL_COUNT) begin
            r.cell_val = screen_mirror[idx];
         end
      end else if (ch == CODE_NULL) begin
         n_nulls++;
      end else if (ch == CODE_BACKSPACE) begin
         n_backspaces++;
         if (cur_row != 0 || cur_col != 0) begin
            if (cur_col != 0) begin
               cur_col--;
            end else begin
               cur_col = COLUMNS - 1;
               cur_row--;
            end
            pos = cur_row * COLUMNS + cur_col;
            screen_mirror[pos] = screen_mirror[pos] & ATTR_MASK;
         end
      end else if (ch == CODE_NEWLINE) begin
         n_newlines++;
         advance_row();
      end else begin
         n_chars++;
         pos = cur_row * COLUMNS + cur_col;
         screen_mirror[pos] = (screen_mirror[pos] & ATTR_MASK) | {8'h00, ch};
         cur_col++;
         if (cur_col >= COLUMNS) begin
            advance_row();
         end
      end
      r.row = cur_row[ROW_W-1:0];
      r.col = cur_col[COL_W-1:0];
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic cmd, input logic [CHAR_W-1:0] ch,
                               input logic [ADDR_W-1:0] idx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.char_code  <= ch;
      req_ch.cell_index <= idx;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      awaited_readouts.push_back(console_apply(cmd, ch, idx));
      @(negedge clock);
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch);
      send_request(CMD_PUT, ch, ADDR_W'($urandom_range(2047)));
   endtask

   task automatic read_cell(input int unsigned idx);
      send_request(CMD_READ, CHAR_W'($urandom_range(255)), idx[ADDR_W-1:0]);
   endtask

   function automatic logic [CHAR_W-1:0] random_printable();
      logic [CHAR_W-1:0] ch;
      do begin
         ch = CHAR_W'($urandom_range(255));
      end while (ch == CODE_NULL || ch == CODE_BACKSPACE || ch == CODE_NEWLINE);
      return ch;
   endfunction

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      readout_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_readouts.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response cell=%h row=%0d col=%0d", $time,
                     rsp_ch.cell_value, rsp_ch.cursor_row, rsp_ch.cursor_col);
         end else begin
            want = awaited_readouts.pop_front();
            if (rsp_ch.cell_value !== want.cell_val) begin
               mismatches++;
               $display("%0t: cell_value expected %h actual %h", $time,
                        want.cell_val, rsp_ch.cell_value);
            end
            if (rsp_ch.cursor_row !== want.row) begin
               mismatches++;
               $display("%0t: cursor_row expected %0d actual %0d", $time,
                        want.row, rsp_ch.cursor_row);
            end
            if (rsp_ch.cursor_col !== want.col) begin
               mismatches++;
               $display("%0t: cursor_col expected %0d actual %0d", $time,
                        want.col, rsp_ch.cursor_col);
            end
         end
      end
   end

   task automatic test_reset_contents();
      read_cell(0);
      read_cell(CELL_COUNT - 1);
      read_cell(CELL_COUNT);
      read_cell(2047);
   endtask

   task automatic test_put_edges();
      put_char(CODE_BACKSPACE);   // at origin
      put_char(CODE_NULL);
      put_char(8'h01);
      put_char(8'hFF);
      put_char(8'h7F);
      put_char(8'h80);
      read_cell(0);
      read_cell(3);
      put_char(CODE_BACKSPACE);
      read_cell(3);
      put_char(CODE_NEWLINE);
      put_char(CODE_BACKSPACE);   // back to last column of row 0
      read_cell(COLUMNS - 1);
      put_char(8'h41);
      read_cell(COLUMNS - 1);
   endtask

   task automatic test_bottom_scroll();
      while (cur_row != ROWS - 1) begin
         put_char(CODE_NEWLINE);
      end
      put_char(8'h5A);
      put_char(8'h51);
      put_char(CODE_NEWLINE);     // scroll
      read_cell((ROWS - 2) * COLUMNS);
      read_cell((ROWS - 2) * COLUMNS + 1);
      read_cell((ROWS - 1) * COLUMNS);
      read_cell(0);
   endtask

   task automatic test_random_text(input int count);
      int pick;
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            put_char(random_printable());
         end else if (pick < 65) begin
            put_char(CODE_NEWLINE);
         end else if (pick < 73) begin
            put_char(CODE_BACKSPACE);
         end else if (pick < 75) begin
            put_char(CODE_NULL);
         end else if (pick < 88) begin
            r = (cur_row > 0 && $urandom_range(1)) ? cur_row - 1 : cur_row;
            read_cell(r * COLUMNS + $urandom_range(COLUMNS - 1));
         end else begin
            read_cell($urandom_range(2047));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_PUT;
      req_ch.char_code  = CODE_NULL;
      req_ch.cell_index = '0;
      rsp_ch.ready      = 1'b0;
      sender_idle_pct   = 0;
      sink_stall_pct    = 0;
      mismatches        = 0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         screen_mirror[i] = BLANK_CELL;
      end
      cur_row = 0;
      cur_col = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_contents();
      test_put_edges();
      test_bottom_scroll();

      sender_idle_pct = 0;  sink_stall_pct = 0;
      test_random_text(480);
      sender_idle_pct = 70; sink_stall_pct = 0;
      test_random_text(480);
      sender_idle_pct = 0;  sink_stall_pct = 70;
      test_random_text(480);
      sender_idle_pct = 22; sink_stall_pct = 22;
      test_random_text(480);

      req_ch.valid   <= 1'b0;
      sink_stall_pct = 0;
      while (awaited_readouts.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("covered %0d chars, %0d newlines, %0d backspaces, %0d null bytes, %0d reads",
               n_chars, n_newlines, n_backspaces, n_nulls, n_reads);
      $display("screen scrolled %0d times; final cursor row %0d col %0d",
               n_scrolls, cur_row, cur_col);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("timeout waiting for console responses");
      $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
